/* src/speech_end_capture_control_top_macros.svh */
// assertion macros for the speech end capture control block
`ifndef SPEECH_END_CAPTURE_CONTROL_TOP_MACROS_SVH
`define SPEECH_END_CAPTURE_CONTROL_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SECD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SECD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/secd_pkg.sv */
// shared types and constants for the speech end capture control block
`default_nettype none

package secd_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CNT_W    = 18;
  localparam int unsigned ADDR_W   = 17;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned SESS_W   = 32;
  localparam int unsigned PEAK_W   = 15;
  localparam int unsigned CFG_W    = 18;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] RUN_MAX = '1;
  localparam logic [MS_W-1:0]  MS_MAX  = '1;

  // mode_now code reported while the capture is being sent
  localparam logic [1:0] MODE_NOW_SEND = 2'd2;

  // register reset values
  localparam logic [PEAK_W-1:0] RST_SPEECH_PEAK     = 15'd3500;
  localparam logic [CNT_W-1:0]  RST_SILENCE_SAMPLES = 18'd14400;
  localparam logic [MS_W-1:0]   RST_MIN_CAPTURE_MS  = 16'd500;
  localparam logic [MS_W-1:0]   RST_MAX_CAPTURE_MS  = 16'd6000;
  localparam logic [CNT_W-1:0]  RST_CAPACITY        = 18'd96000;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_TICK    = 2'd1,
    OP_REQUEST = 2'd2,
    OP_DRAIN   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEECH_PEAK     = 3'd0,
    CFG_SILENCE_SAMPLES = 3'd1,
    CFG_MIN_CAPTURE_MS  = 3'd2,
    CFG_MAX_CAPTURE_MS  = 3'd3,
    CFG_CAPACITY        = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [PEAK_W-1:0] speech_peak;
    logic [CNT_W-1:0]  silence_samples;
    logic [MS_W-1:0]   min_capture_ms;
    logic [MS_W-1:0]   max_capture_ms;
    logic [CNT_W-1:0]  capacity;
  } cfg_t;

  typedef struct packed {
    logic                reply_pending;
    logic [1:0]          mode_now;
    logic [SESS_W-1:0]   session_number;
    logic [CNT_W-1:0]    captured_length;
    logic                end_reason;
    logic                capture_done;
    logic [SAMPLE_W-1:0] store_sample;
    logic [ADDR_W-1:0]   store_addr;
    logic                store_valid;
  } res_t;

endpackage

`default_nettype wire

/* src/secd_cfg.sv */
// configuration register file
`default_nettype none

module secd_cfg import secd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]     wr_data,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speech_peak     <= RST_SPEECH_PEAK;
      cfg_r.silence_samples <= RST_SILENCE_SAMPLES;
      cfg_r.min_capture_ms  <= RST_MIN_CAPTURE_MS;
      cfg_r.max_capture_ms  <= RST_MAX_CAPTURE_MS;
      cfg_r.capacity        <= RST_CAPACITY;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_SPEECH_PEAK:     cfg_r.speech_peak     <= wr_data[PEAK_W-1:0];
        CFG_SILENCE_SAMPLES: cfg_r.silence_samples <= wr_data[CNT_W-1:0];
        CFG_MIN_CAPTURE_MS:  cfg_r.min_capture_ms  <= wr_data[MS_W-1:0];
        CFG_MAX_CAPTURE_MS:  cfg_r.max_capture_ms  <= wr_data[MS_W-1:0];
        CFG_CAPACITY:        cfg_r.capacity        <= wr_data[CNT_W-1:0];
        default: ; // unused indexes are ignored
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* src/secd_ctrl.sv */
// capture control state and per-item result logic
`default_nettype none

module secd_ctrl import secd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 131072
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire logic [1:0]          op,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                frame_last,
  input  wire cfg_t                cfg,
  output res_t                     res
);

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_CAPTURE = 2'd1,
    MODE_SEND    = 2'd2
  } mode_t;

  // store depth clipped to what the counters can hold
  localparam logic [CNT_W-1:0] DEPTH_CAP =
    (STORE_DEPTH > 262143) ? RUN_MAX : CNT_W'(STORE_DEPTH);

  mode_t               mode_r, mode_nxt;
  logic                armed_r, armed_nxt;
  logic                frm_start_r, frm_start_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] peak_r, peak_nxt;
  logic [CNT_W-1:0]    taken_r, taken_nxt;
  logic                speech_r, speech_nxt;
  logic [CNT_W-1:0]    run_r, run_nxt;
  logic [MS_W-1:0]     ms_r, ms_nxt;
  logic [SESS_W-1:0]   sess_r, sess_nxt;
  logic                reply_r, reply_nxt;

  logic [CNT_W-1:0]    limit;
  logic [SAMPLE_W-1:0] mag;
  logic                start;
  logic                room;
  logic                loud;
  logic [CNT_W:0]      run_sum;
  logic                vad;
  logic                maxed;

  assign limit = (cfg.capacity < DEPTH_CAP) ? cfg.capacity : DEPTH_CAP;
  // two's complement negate keeps the most negative code as 0x8000
  assign mag   = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign start = (mode_r == MODE_IDLE) && frm_start_r && armed_r;

  always_comb begin
    mode_nxt      = mode_r;
    armed_nxt     = armed_r;
    frm_start_nxt = frm_start_r;
    cnt_nxt       = cnt_r;
    peak_nxt      = peak_r;
    taken_nxt     = taken_r;
    speech_nxt    = speech_r;
    run_nxt       = run_r;
    ms_nxt        = ms_r;
    sess_nxt      = sess_r;
    reply_nxt     = reply_r;
    room          = 1'b0;
    loud          = 1'b0;
    run_sum       = '0;
    vad           = 1'b0;
    maxed         = 1'b0;
    res           = '0;

    unique case (op_t'(op))
      OP_TICK: begin
        if (mode_r == MODE_CAPTURE && ms_r != MS_MAX) ms_nxt = ms_r + 1'b1;
      end
      OP_REQUEST: begin
        armed_nxt = 1'b1;
      end
      OP_DRAIN: begin
        if (mode_r == MODE_SEND) begin
          reply_nxt = 1'b1;
          mode_nxt  = MODE_IDLE;
        end
      end
      default: begin // sample
        if (start) begin
          armed_nxt  = 1'b0;
          reply_nxt  = 1'b0;
          cnt_nxt    = '0;
          speech_nxt = 1'b0;
          run_nxt    = '0;
          ms_nxt     = '0;
          peak_nxt   = '0;
          taken_nxt  = '0;
          sess_nxt   = sess_r + 1'b1;
          mode_nxt   = MODE_CAPTURE;
        end
        if (mode_nxt == MODE_CAPTURE) begin
          room = cnt_nxt < limit;
          if (room) begin
            res.store_valid  = 1'b1;
            res.store_addr   = cnt_nxt[ADDR_W-1:0];
            res.store_sample = sample;
            cnt_nxt          = cnt_nxt + 1'b1;
            taken_nxt        = taken_nxt + 1'b1;
            if (mag > peak_nxt) peak_nxt = mag;
          end
          if (frame_last) begin
            loud = peak_nxt > {1'b0, cfg.speech_peak};
            if (loud) begin
              speech_nxt = 1'b1;
              run_nxt    = '0;
            end else if (speech_nxt) begin
              run_sum = {1'b0, run_nxt} + {1'b0, taken_nxt};
              run_nxt = run_sum[CNT_W] ? RUN_MAX : run_sum[CNT_W-1:0];
            end
            vad   = speech_nxt && (run_nxt >= cfg.silence_samples) &&
                    (ms_nxt >= cfg.min_capture_ms);
            maxed = (cnt_nxt >= limit) || (ms_nxt >= cfg.max_capture_ms);
            if (vad || maxed) begin
              mode_nxt         = MODE_SEND;
              res.capture_done = 1'b1;
              res.end_reason   = vad;
            end
            peak_nxt  = '0;
            taken_nxt = '0;
          end
        end
        frm_start_nxt = frame_last;
      end
    endcase

    res.captured_length = cnt_nxt;
    res.session_number  = sess_nxt;
    res.mode_now        = 2'(mode_nxt);
    res.reply_pending   = reply_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      armed_r     <= 1'b0;
      frm_start_r <= 1'b1;
      cnt_r       <= '0;
      peak_r      <= '0;
      taken_r     <= '0;
      speech_r    <= 1'b0;
      run_r       <= '0;
      ms_r        <= '0;
      sess_r      <= '0;
      reply_r     <= 1'b0;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      armed_r     <= armed_nxt;
      frm_start_r <= frm_start_nxt;
      cnt_r       <= cnt_nxt;
      peak_r      <= peak_nxt;
      taken_r     <= taken_nxt;
      speech_r    <= speech_nxt;
      run_r       <= run_nxt;
      ms_r        <= ms_nxt;
      sess_r      <= sess_nxt;
      reply_r     <= reply_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/speech_end_capture_control_top.sv */
// top level of the speech end capture control block
`default_nettype none

// Speech end capture control. Each input item is a microphone sample, a
// millisecond tick, a capture request or a drain-finished event, and each
// one gives exactly one result item. A capture opens at the first frame
// start after a request, stores samples up to the smaller of the capacity
// register and STORE_DEPTH, and at each frame end decides on speech and on
// ending: silence after speech once the minimum time is reached (reason 1),
// or a full store or the maximum time (reason 0). The block takes one item
// per clock while the result channel is not stalled: an input register holds
// the item, and the control logic updates its state and fills a result
// register in the same cycle as the item moves on. The input side keeps
// taking items while a result waits, as long as the input register is empty
// or the result register will free up in that cycle. Configuration writes
// are taken in any cycle but are only meant to change while the block is
// idle. There is no memory and no clearing pass after reset.

module speech_end_capture_control_top import secd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 131072
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input item channel
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [15:0]          in_tdata,  // [15:0] sample
  input  wire logic [1:0]           in_tuser,  // [1:0] op
  input  wire logic                 in_tlast,  // frame_last
  // result item channel
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [16:0] store_addr, [32:17] store_sample, [33] capture_done,
  // [34] end_reason, [52:35] captured_length, [84:53] session_number,
  // [86:85] mode_now, [87] reply_pending
  output logic [87:0]               out_tdata,
  output logic                      out_tuser, // [0] store_valid
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // input register
  logic                in_vld_r;
  logic [1:0]          in_op_r;
  logic [SAMPLE_W-1:0] in_sample_r;
  logic                in_last_r;

  // result register
  logic out_vld_r;
  res_t out_res_r;

  cfg_t cfg;
  res_t res;
  logic fire;

  // the held item moves on whenever the result register is free or emptying
  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r     <= in_tuser;
      in_sample_r <= in_tdata;
      in_last_r   <= in_tlast;
    end
  end

  secd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  secd_ctrl #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .op         (in_op_r),
    .sample     (in_sample_r),
    .frame_last (in_last_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.store_valid;
  assign out_tdata  = {out_res_r.reply_pending,
                       out_res_r.mode_now,
                       out_res_r.session_number,
                       out_res_r.captured_length,
                       out_res_r.end_reason,
                       out_res_r.capture_done,
                       out_res_r.store_sample,
                       out_res_r.store_addr};

`include "speech_end_capture_control_top_macros.svh"

  // a stored sample is always the last one counted
  `SECD_ASSERT_IMP(a_addr_tracks_len, out_vld_r && out_res_r.store_valid, out_res_r.store_addr == ADDR_W'(out_res_r.captured_length - 1'b1), "store address does not follow captured length")
  // the item that ends a capture leaves the block sending
  `SECD_ASSERT_IMP(a_done_sends, out_vld_r && out_res_r.capture_done, out_res_r.mode_now == MODE_NOW_SEND, "capture ended but not sending")
  // a reason is only given with an end of capture
  `SECD_ASSERT_IMP(a_reason_done, out_vld_r && out_res_r.end_reason, out_res_r.capture_done, "end reason without capture end")
  // an empty result register never holds the input back
  `SECD_ASSERT_IMP(a_no_idle_stall, !out_vld_r, in_tready, "input stalled with empty result register")
  // a result follows every item that moves on
  `SECD_ASSERT_NXT(a_fire_result, fire, out_vld_r, "item moved on without a result")

endmodule

`default_nettype wire
